// File: hw/rtl/fklt_pkg.sv
package fklt_pkg;

    localparam int LOCK_ENTRIES = 64;
    localparam int QUEUE_DEPTH  = 8;
    localparam int TXN_SLOTS    = 64;
    localparam int PART_SHIFT   = 48;
    localparam int ENTRY_W      = $clog2(LOCK_ENTRIES);
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_IDX_W   = $clog2(TXN_SLOTS);
    localparam int SLOT_W       = 6;
    localparam int KEY_W        = 64;
    localparam int PART_W       = 16;
    localparam int WAIT_W       = 7;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 7'd127;
    localparam int FIFO_AW      = ENTRY_W + QPTR_W;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TBL_FULL = 2'd1;
    localparam logic [1:0] ST_Q_FULL   = 2'd2;
    localparam logic [1:0] ST_NOT_OWN  = 2'd3;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FIFO_RD,
        S_GRANT,
        S_CHECK,
        S_OUT
    } state_t;

    // scan result handed from the search unit to the sequencer
    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] hit_idx;
        logic               free_found;
        logic [ENTRY_W-1:0] free_idx;
    } scan_res_t;

endpackage

// File: hw/rtl/fklt_scan.sv
module fklt_scan (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [fklt_pkg::KEY_W-1:0]       key,
    input  logic                             ent_valid,
    input  logic [fklt_pkg::KEY_W-1:0]       ent_key,
    output logic [fklt_pkg::ENTRY_W-1:0]     idx,
    output logic                             done,
    output fklt_pkg::scan_res_t              res
);

    localparam int CNT_W = fklt_pkg::ENTRY_W + 1;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    fklt_pkg::scan_res_t     res_reg, res_next;
    logic [fklt_pkg::ENTRY_W-1:0] prev_reg;
    logic                    chk_reg;

    // entry data comes from a registered read of the issued index
    assign idx  = cnt_reg[fklt_pkg::ENTRY_W-1:0];
    assign done = chk_reg && !busy_reg;
    assign res  = res_next;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        res_next  = res_reg;
        if (start) begin
            cnt_next  = '0;
            busy_next = 1'b1;
            res_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(fklt_pkg::LOCK_ENTRIES - 1)) begin
                busy_next = 1'b0;
            end
        end
        if (chk_reg && !start) begin
            if (ent_valid && ent_key == key && !res_reg.hit) begin
                res_next.hit     = 1'b1;
                res_next.hit_idx = prev_reg;
            end
            if (!ent_valid && !res_reg.free_found) begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = prev_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            res_reg  <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            chk_reg  <= busy_reg && !start;
            res_reg  <= res_next;
        end
        prev_reg <= idx;
    end

endmodule

// File: hw/rtl/fifo_key_lock_table.sv
// Exclusive lock manager, one FIFO of waiting slots per key.
// Channels: s_ (action, txn_slot, lock_key, last_key) in, m_ (ready_valid,
// ready_txn, status) out, and a cfg_ write channel carrying local_partition.
// Every input transfer gives exactly one result transfer.
// An item is taken only while the block is idle; s_ready and cfg_ready stay
// low from the input transfer until the result transfer.
// For a local key the search walks the lock table one entry a cycle through
// the table memory read port; the result is offered after the walk and the
// update, check and output states, with queue read and grant states between
// update and check when a release hands the key to a waiter. The next item
// can be taken in the cycle after the result transfer.
// Foreign-partition keys skip the search: the scan state goes straight to the
// check state, and the result is then offered.
// The result sits in an output register; while m_ready is low it holds and
// no new item is taken.
// Reset clears the entry valid bits and the per-slot wait flags; queue head
// and count are set when an entry is taken, and a wait count reads as zero
// until first written.
module fifo_key_lock_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [5:0]  s_txn_slot,
    input  logic signed [63:0] s_lock_key,
    input  logic        s_last_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ready_valid,
    output logic [5:0]  m_ready_txn,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int EW = fklt_pkg::ENTRY_W;
    localparam int QW = fklt_pkg::QPTR_W;
    localparam int CW = fklt_pkg::QCNT_W;
    localparam int SW = fklt_pkg::SLOT_IDX_W;
    localparam int WW = fklt_pkg::WAIT_W;

    fklt_pkg::state_t state_reg, state_next;

    logic [15:0] part_reg;

    logic        act_reg;
    logic [5:0]  slot_reg;
    logic [63:0] key_reg;
    logic        last_reg;

    logic        rv_reg, rv_next;
    logic [5:0]  rt_reg, rt_next;
    logic [1:0]  st_reg, st_next;

    // stores
    logic [63:0]   key_mem   [fklt_pkg::LOCK_ENTRIES];
    logic [5:0]    owner_mem [fklt_pkg::LOCK_ENTRIES];
    logic [5:0]    fifo_mem  [fklt_pkg::LOCK_ENTRIES * fklt_pkg::QUEUE_DEPTH];
    logic [QW-1:0] head_mem  [fklt_pkg::LOCK_ENTRIES];
    logic [CW-1:0] cnt_mem   [fklt_pkg::LOCK_ENTRIES];
    logic [WW-1:0] wait_mem  [fklt_pkg::TXN_SLOTS];
    logic [fklt_pkg::LOCK_ENTRIES-1:0] valid_reg;
    logic [fklt_pkg::TXN_SLOTS-1:0]    wait_ok_reg;

    logic [63:0]   key_rd;
    logic          valid_rd;
    logic [5:0]    owner_rd;
    logic [5:0]    fifo_rd;
    logic [QW-1:0] head_rd;
    logic [CW-1:0] cnt_rd;
    logic [WW-1:0] wait_rd;
    logic          wait_ok_rd;
    logic [WW-1:0] wait_cur;
    logic [SW-1:0] wait_addr;
    logic [EW-1:0] ent_addr;
    logic [EW-1:0] scan_prev_reg;

    logic        scan_start;
    logic [EW-1:0] scan_idx;
    logic        scan_done;
    fklt_pkg::scan_res_t scan_res, res_reg;

    logic [5:0]  next_reg;
    logic [EW-1:0] e_idx;
    logic        local_key;
    logic        queued;

    assign local_key = key_reg[fklt_pkg::PART_SHIFT +: fklt_pkg::PART_W] == part_reg;
    assign e_idx     = res_reg.hit ? res_reg.hit_idx : res_reg.free_idx;
    assign ent_addr  = scan_done ? scan_res.hit_idx : e_idx;
    assign wait_addr = (state_reg == fklt_pkg::S_FIFO_RD) ? fifo_rd[SW-1:0]
                                                          : slot_reg[SW-1:0];
    assign wait_cur  = wait_ok_rd ? wait_rd : '0;
    // a queued acquire leaves the slot waiting, whatever count was read before
    assign queued    = local_key && res_reg.hit && st_reg == fklt_pkg::ST_OK;
    // valid bit sampled alongside the registered key
    assign valid_rd  = valid_reg[scan_prev_reg];

    fklt_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .key       (key_reg),
        .ent_valid (valid_rd),
        .ent_key   (key_rd),
        .idx       (scan_idx),
        .done      (scan_done),
        .res       (scan_res)
    );

    assign s_ready       = state_reg == fklt_pkg::S_IDLE;
    assign cfg_ready     = state_reg == fklt_pkg::S_IDLE;
    assign m_valid       = state_reg == fklt_pkg::S_OUT;
    assign m_ready_valid = rv_reg;
    assign m_ready_txn   = rt_reg;
    assign m_status      = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fklt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        scan_start = 1'b0;
        case (state_reg)
            fklt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = fklt_pkg::S_SCAN;
                end
            end
            fklt_pkg::S_SCAN: begin
                if (!local_key) begin
                    state_next = fklt_pkg::S_CHECK;
                end else if (scan_done) begin
                    state_next = fklt_pkg::S_UPDATE;
                end
            end
            fklt_pkg::S_UPDATE: begin
                if (act_reg == fklt_pkg::ACT_RELEASE && res_reg.hit
                    && owner_rd == slot_reg && cnt_rd != '0) begin
                    state_next = fklt_pkg::S_FIFO_RD;
                end else begin
                    state_next = fklt_pkg::S_CHECK;
                end
            end
            fklt_pkg::S_FIFO_RD: state_next = fklt_pkg::S_GRANT;
            fklt_pkg::S_GRANT:   state_next = fklt_pkg::S_CHECK;
            fklt_pkg::S_CHECK:   state_next = fklt_pkg::S_OUT;
            fklt_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = fklt_pkg::S_IDLE;
                end
            end
            default: state_next = fklt_pkg::S_IDLE;
        endcase
        if (state_reg == fklt_pkg::S_IDLE && s_valid) begin
            scan_start = 1'b1;
        end
    end

    // table memory reads: scan address while searching, chosen entry after
    always_ff @(posedge aclk) begin
        key_rd        <= key_mem[scan_idx];
        owner_rd      <= owner_mem[ent_addr];
        head_rd       <= head_mem[ent_addr];
        cnt_rd        <= cnt_mem[ent_addr];
        fifo_rd       <= fifo_mem[{e_idx, head_rd}];
        wait_rd       <= wait_mem[wait_addr];
        wait_ok_rd    <= wait_ok_reg[wait_addr];
        scan_prev_reg <= scan_idx;
    end

    always_comb begin
        rv_next = rv_reg;
        rt_next = rt_reg;
        st_next = st_reg;
        case (state_reg)
            fklt_pkg::S_IDLE: begin
                rv_next = 1'b0;
                rt_next = '0;
                st_next = fklt_pkg::ST_OK;
            end
            fklt_pkg::S_UPDATE: begin
                if (act_reg == fklt_pkg::ACT_ACQUIRE) begin
                    if (!res_reg.hit && !res_reg.free_found) begin
                        st_next = fklt_pkg::ST_TBL_FULL;
                    end else if (res_reg.hit && cnt_rd >= CW'(fklt_pkg::QUEUE_DEPTH)) begin
                        st_next = fklt_pkg::ST_Q_FULL;
                    end
                end else if (!res_reg.hit || owner_rd != slot_reg) begin
                    st_next = fklt_pkg::ST_NOT_OWN;
                end
            end
            fklt_pkg::S_GRANT: begin
                if (wait_cur <= WW'(1)) begin
                    rv_next = 1'b1;
                    rt_next = next_reg;
                end
            end
            fklt_pkg::S_CHECK: begin
                if (act_reg == fklt_pkg::ACT_ACQUIRE && last_reg && !queued
                    && wait_cur == '0) begin
                    rv_next = 1'b1;
                    rt_next = slot_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg    <= '0;
            valid_reg   <= '0;
            wait_ok_reg <= '0;
            rv_reg      <= 1'b0;
            rt_reg      <= '0;
            st_reg      <= fklt_pkg::ST_OK;
            res_reg     <= '0;
        end else begin
            rv_reg <= rv_next;
            rt_reg <= rt_next;
            st_reg <= st_next;
            if (cfg_valid && cfg_ready) begin
                part_reg <= cfg_data;
            end
            if (state_reg == fklt_pkg::S_SCAN && scan_done) begin
                res_reg <= scan_res;
            end
            if (state_reg == fklt_pkg::S_UPDATE) begin
                if (act_reg == fklt_pkg::ACT_ACQUIRE) begin
                    if (!res_reg.hit && res_reg.free_found) begin
                        valid_reg[res_reg.free_idx] <= 1'b1;
                    end else if (res_reg.hit
                                 && cnt_rd < CW'(fklt_pkg::QUEUE_DEPTH)) begin
                        wait_ok_reg[slot_reg[SW-1:0]] <= 1'b1;
                    end
                end else if (res_reg.hit && owner_rd == slot_reg && cnt_rd == '0) begin
                    valid_reg[e_idx] <= 1'b0;
                end
            end
            if (state_reg == fklt_pkg::S_GRANT) begin
                wait_ok_reg[next_reg[SW-1:0]] <= 1'b1;
            end
        end
    end

    // payload capture and store writes
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            slot_reg <= s_txn_slot;
            key_reg  <= s_lock_key;
            last_reg <= s_last_key;
        end
        if (state_reg == fklt_pkg::S_FIFO_RD) begin
            next_reg         <= fifo_rd;
            owner_mem[e_idx] <= fifo_rd;
            head_mem[e_idx]  <= QW'(head_rd + 1'b1);
            cnt_mem[e_idx]   <= cnt_rd - 1'b1;
        end
        if (state_reg == fklt_pkg::S_UPDATE && act_reg == fklt_pkg::ACT_ACQUIRE) begin
            if (!res_reg.hit && res_reg.free_found) begin
                key_mem[res_reg.free_idx]   <= key_reg;
                owner_mem[res_reg.free_idx] <= slot_reg;
                head_mem[res_reg.free_idx]  <= '0;
                cnt_mem[res_reg.free_idx]   <= '0;
            end else if (res_reg.hit && cnt_rd < CW'(fklt_pkg::QUEUE_DEPTH)) begin
                fifo_mem[{res_reg.hit_idx, QW'(head_rd + cnt_rd[QW-1:0])}] <= slot_reg;
                cnt_mem[res_reg.hit_idx] <= cnt_rd + 1'b1;
                // saturate the wait count
                wait_mem[slot_reg[SW-1:0]] <= (wait_cur < fklt_pkg::WAIT_MAX)
                                              ? WW'(wait_cur + 1'b1) : wait_cur;
            end
        end
        if (state_reg == fklt_pkg::S_GRANT) begin
            wait_mem[next_reg[SW-1:0]] <= (wait_cur > WW'(1)) ? WW'(wait_cur - 1'b1) : '0;
        end
    end

endmodule

// File: tb/sv/fifo_key_lock_table_test.sv
`timescale 1ns / 100ps

module fifo_key_lock_table_test;

    typedef struct {
        logic        action;
        logic [5:0]  slot;
        logic [63:0] key;
        logic        last;
    } lock_req_t;

    typedef struct {
        logic       rdy;
        logic [5:0] txn;
        logic [1:0] status;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [5:0]  s_txn_slot = '0;
    logic [63:0] s_lock_key = '0;
    logic        s_last_key = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ready_valid;
    logic [5:0]  m_ready_txn;
    logic [1:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    fifo_key_lock_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_txn_slot(s_txn_slot), .s_lock_key(s_lock_key), .s_last_key(s_last_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_ready_valid(m_ready_valid),
        .m_ready_txn(m_ready_txn), .m_status(m_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // lock table image
    logic [15:0] part_reg = '0;
    bit          ent_valid [fklt_pkg::LOCK_ENTRIES];
    logic [63:0] ent_key   [fklt_pkg::LOCK_ENTRIES];
    logic [5:0]  ent_owner [fklt_pkg::LOCK_ENTRIES];
    logic [5:0]  waiters   [fklt_pkg::LOCK_ENTRIES][fklt_pkg::QUEUE_DEPTH];
    int          wq_head   [fklt_pkg::LOCK_ENTRIES];
    int          wq_count  [fklt_pkg::LOCK_ENTRIES];
    int          slot_waits[fklt_pkg::TXN_SLOTS];

    lock_req_t   pending_reqs[$];
    grant_t      expected_grants[$];
    logic [63:0] held_keys[$];
    logic [47:0] key_pool[16];

    int send_idle = 0;
    int recv_stall = 0;
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    bit s_taken = 1'b0;
    int fails = 0;

    function automatic int find_key(logic [63:0] key);
        for (int i = 0; i < fklt_pkg::LOCK_ENTRIES; i++)
            if (ent_valid[i] && ent_key[i] == key) return i;
        return -1;
    endfunction

    function automatic grant_t apply_lock_req(lock_req_t rq);
        grant_t r;
        int     e;
        int     sidx;
        bit     in_part;
        logic [5:0] nxt;
        r = '{1'b0, 6'd0, fklt_pkg::ST_OK};
        sidx = rq.slot % fklt_pkg::TXN_SLOTS;
        in_part = (rq.key[63:48] == part_reg);
        if (rq.action == fklt_pkg::ACT_ACQUIRE) begin
            if (in_part) begin
                e = find_key(rq.key);
                if (e < 0) begin
                    for (int i = 0; i < fklt_pkg::LOCK_ENTRIES && e < 0; i++)
                        if (!ent_valid[i]) e = i;
                    if (e < 0) begin
                        r.status = fklt_pkg::ST_TBL_FULL;
                    end else begin
                        ent_valid[e] = 1'b1;
                        ent_key[e] = rq.key;
                        ent_owner[e] = rq.slot;
                        wq_head[e] = 0;
                        wq_count[e] = 0;
                    end
                end else if (wq_count[e] >= fklt_pkg::QUEUE_DEPTH) begin
                    r.status = fklt_pkg::ST_Q_FULL;
                end else begin
                    waiters[e][(wq_head[e] + wq_count[e]) % fklt_pkg::QUEUE_DEPTH] = rq.slot;
                    wq_count[e]++;
                    if (slot_waits[sidx] < fklt_pkg::WAIT_MAX) slot_waits[sidx]++;
                end
            end
            if (rq.last && slot_waits[sidx] == 0) begin
                r.rdy = 1'b1;
                r.txn = rq.slot;
            end
        end else if (in_part) begin
            e = find_key(rq.key);
            if (e < 0 || ent_owner[e] != rq.slot) begin
                r.status = fklt_pkg::ST_NOT_OWN;
            end else if (wq_count[e] > 0) begin
                nxt = waiters[e][wq_head[e]];
                wq_head[e] = (wq_head[e] + 1) % fklt_pkg::QUEUE_DEPTH;
                wq_count[e]--;
                ent_owner[e] = nxt;
                if (slot_waits[nxt % fklt_pkg::TXN_SLOTS] > 0)
                    slot_waits[nxt % fklt_pkg::TXN_SLOTS]--;
                if (slot_waits[nxt % fklt_pkg::TXN_SLOTS] == 0) begin
                    r.rdy = 1'b1;
                    r.txn = nxt;
                end
            end else begin
                ent_valid[e] = 1'b0;
            end
        end
        return r;
    endfunction

    // requests run strictly in order, so predict as they are queued
    task automatic issue(logic act, logic [5:0] slot, logic [63:0] key, logic last);
        lock_req_t rq;
        rq = '{act, slot, key, last};
        expected_grants.push_back(apply_lock_req(rq));
        pending_reqs.push_back(rq);
    endtask

    function automatic logic [63:0] pool_key();
        return {part_reg, key_pool[$urandom_range(15)]};
    endfunction

    function automatic logic [63:0] foreign_key();
        logic [15:0] p;
        p = part_reg ^ 16'($urandom_range(65535, 1));
        return {p, 16'($urandom), 32'($urandom)};
    endfunction

    task automatic wait_drain();
        while (pending_reqs.size() != 0 || expected_grants.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_partition(logic [15:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        part_reg = v;
    endtask

    task automatic free_table();
        for (int e = 0; e < fklt_pkg::LOCK_ENTRIES; e++)
            while (ent_valid[e])
                issue(fklt_pkg::ACT_RELEASE, ent_owner[e], ent_key[e], 1'($urandom));
    endtask

    task automatic run_txns(int n);
        int cnt;
        int k;
        int idx;
        int e;
        logic [5:0]  s;
        logic [63:0] key;
        cnt = 0;
        while (cnt < n) begin
            k = $urandom_range(99);
            if (k < 10) begin
                key = $urandom_range(1) ? pool_key() : {32'($urandom), 32'($urandom)};
                issue(1'($urandom), 6'($urandom), key, 1'($urandom));
                cnt++;
            end else if (k < 40 && held_keys.size() > 0) begin
                idx = $urandom_range(held_keys.size() - 1);
                key = held_keys[idx];
                held_keys.delete(idx);
                e = find_key(key);
                s = (e >= 0 && $urandom_range(9) < 8) ? ent_owner[e] : 6'($urandom);
                issue(fklt_pkg::ACT_RELEASE, s, key, 1'($urandom));
                cnt++;
            end else begin
                s = 6'($urandom);
                k = $urandom_range(4, 1);
                for (int j = 0; j < k; j++) begin
                    key = ($urandom_range(9) == 0) ? foreign_key() : pool_key();
                    issue(fklt_pkg::ACT_ACQUIRE, s, key, j == k - 1);
                    held_keys.push_back(key);
                end
                cnt += k;
            end
        end
    endtask

    // driver: present the next request once the current one has transferred
    always @(negedge aclk) begin : drive_req
        lock_req_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                rq = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_action <= rq.action;
                s_txn_slot <= rq.slot;
                s_lock_key <= rq.key;
                s_last_key <= rq.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= 300;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor
    always @(posedge aclk) begin : check_grant
        grant_t g;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    $error("unexpected result transfer");
                    fails++;
                end else begin
                    g = expected_grants.pop_front();
                    if (m_ready_valid !== g.rdy) begin
                        $error("ready_valid: expected %0d actual %0d", g.rdy, m_ready_valid);
                        fails++;
                    end
                    if (m_ready_txn !== g.txn) begin
                        $error("ready_txn: expected %0d actual %0d", g.txn, m_ready_txn);
                        fails++;
                    end
                    if (m_status !== g.status) begin
                        $error("status: expected %0d actual %0d", g.status, m_status);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [15:0] parts[8];
        int          modes[4][2];
        for (int i = 0; i < fklt_pkg::LOCK_ENTRIES; i++) begin
            ent_valid[i] = 1'b0;
            wq_head[i] = 0;
            wq_count[i] = 0;
        end
        foreach (slot_waits[i]) slot_waits[i] = 0;
        modes = '{'{0, 0}, '{86, 0}, '{0, 86}, '{19, 19}};
        parts = '{16'hFFFF, 16'($urandom), 16'h0000, 16'h8000,
                  16'($urandom), 16'h0001, 16'($urandom), 16'hFFFF};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: partition 0 from reset
        issue(fklt_pkg::ACT_ACQUIRE, 6'd5, 64'h0, 1'b1);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd9, 64'h0, 1'b0);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd9, 64'hFFFF_0000_0000_0001, 1'b1);
        issue(fklt_pkg::ACT_RELEASE, 6'd9, 64'h0, 1'b0);
        issue(fklt_pkg::ACT_RELEASE, 6'd9, 64'h0000_1234_5678_9ABC, 1'b0);
        issue(fklt_pkg::ACT_RELEASE, 6'd9, 64'h8000_0000_0000_0000, 1'b0);
        issue(fklt_pkg::ACT_RELEASE, 6'd5, 64'h0, 1'b1);
        issue(fklt_pkg::ACT_RELEASE, 6'd9, 64'h0, 1'b0);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd63, 64'h0000_FFFF_FFFF_FFFF, 1'b0);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd63, 64'h0000_FFFF_FFFF_FFFF, 1'b1);
        issue(fklt_pkg::ACT_RELEASE, 6'd63, 64'h0000_FFFF_FFFF_FFFF, 1'b0);
        issue(fklt_pkg::ACT_RELEASE, 6'd63, 64'h0000_FFFF_FFFF_FFFF, 1'b0);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd0, 64'h0000_0000_0000_0007, 1'b0);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd3, 64'h0000_0000_0000_0007, 1'b1);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd4, 64'h0000_0000_0000_0008, 1'b0);
        issue(fklt_pkg::ACT_RELEASE, 6'd0, 64'h0000_0000_0000_0007, 1'b0);
        issue(fklt_pkg::ACT_ACQUIRE, 6'd3, 64'h0000_0000_0000_0009, 1'b1);
        free_table();
        wait_drain();

        for (int p = 0; p < 8; p++) begin
            write_partition(parts[p]);
            send_idle = modes[p % 4][0];
            recv_stall = modes[p % 4][1];
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < 16; i++) key_pool[i] = {16'($urandom), 32'($urandom)};
            held_keys.delete();
            if (p == 1) hold_go = ~hold_go;
            run_txns(50);
            free_table();
            if (p == 2) begin
                // table full: more distinct keys than entries
                for (int i = 0; i < fklt_pkg::LOCK_ENTRIES + 6; i++)
                    issue(fklt_pkg::ACT_ACQUIRE, 6'($urandom),
                          {part_reg, 16'($urandom), 32'(i)},
                          i == fklt_pkg::LOCK_ENTRIES + 5);
                free_table();
            end
            if (p == 4) begin
                // queue full and wait count saturation
                for (int i = 0; i < 16; i++)
                    issue(fklt_pkg::ACT_ACQUIRE, 6'd1, {part_reg, 48'(i)}, i == 15);
                for (int i = 0; i < 16; i++)
                    for (int j = 0; j < fklt_pkg::QUEUE_DEPTH; j++)
                        issue(fklt_pkg::ACT_ACQUIRE, 6'd2, {part_reg, 48'(i)}, 1'b0);
                issue(fklt_pkg::ACT_ACQUIRE, 6'd2, {part_reg, 48'(0)}, 1'b1);
                free_table();
            end
            wait_drain();
        end

        repeat (100) @(posedge aclk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
